/* rtl/rcp_pkg.sv */
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants for the request command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_INLINE  = 4'd1;
  localparam logic [3:0] PH_COUNT   = 4'd2;
  localparam logic [3:0] PH_HEADER  = 4'd3;
  localparam logic [3:0] PH_PAYLOAD = 4'd4;
  localparam logic [3:0] PH_TRAILER = 4'd5;
  localparam logic [3:0] PH_ERROR   = 4'd6;

  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_END   = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERROR = 2'd3;

  localparam logic [2:0] E_INLINE_LONG = 3'd0;
  localparam logic [2:0] E_COUNT_LONG  = 3'd1;
  localparam logic [2:0] E_BAD_COUNT   = 3'd2;
  localparam logic [2:0] E_EXP_DOLLAR  = 3'd3;
  localparam logic [2:0] E_BAD_LEN     = 3'd4;

  localparam logic [1:0] CFG_MAX_INLINE = 2'd0;
  localparam logic [1:0] CFG_MAX_ARGS   = 2'd1;
  localparam logic [1:0] CFG_MAX_BULK   = 2'd2;

  localparam logic [16:0] LEN_SAT   = 17'h1FFFF;
  localparam logic [32:0] NUM_LIMIT = 33'h080000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        first_of_arg;
    logic [19:0] arg_index;
    logic [29:0] arg_length;
    logic [20:0] arg_count;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

endpackage

/* rtl/resp_command_parser.sv */
// ----------------------------------------------------------------------------
// resp_command_parser
// Byte-serial request parser: array and inline commands to argument results.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle when the result queue has room. Each byte
// is decoded combinationally from the registered parser state and yields
// zero, one or two results into a 4-entry result FIFO; the output side
// drains one result per cycle while out_ready is high. A byte that gives two
// results writes both into the FIFO together; input is held off only while fewer than two
// FIFO entries are free. Configuration is written through cfg_* while idle.
module resp_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_first_of_arg,
  output logic [19:0] out_arg_index,
  output logic [29:0] out_arg_length,
  output logic [20:0] out_arg_count,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  logic [16:0] max_inline_r;
  logic [20:0] max_args_r;
  logic [29:0] max_bulk_r;

  logic [3:0]  phase_r, phase_nxt;
  logic        cr_r, cr_nxt, inv_r, inv_nxt, neg_r, neg_nxt, dig_r, dig_nxt;
  logic        inw_r, inw_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [20:0] exp_r, exp_nxt, cur_r, cur_nxt;
  logic [29:0] rem_r, rem_nxt;
  logic [1:0]  trl_r, trl_nxt;
  logic [16:0] ll_r, ll_nxt, wl_r, wl_nxt;

  // result FIFO
  rcp_pkg::result_t fifo_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  rcp_pkg::result_t r0, r1;
  logic [1:0] nres;
  logic acc_in, acc_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt_r <= 3'd2);
  assign acc_in    = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign acc_out   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_inline_r <= 17'd65536;
      max_args_r   <= 21'd1048576;
      max_bulk_r   <= 30'd536870912;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcp_pkg::CFG_MAX_INLINE: max_inline_r <= cfg_data[16:0];
        rcp_pkg::CFG_MAX_ARGS:   max_args_r   <= cfg_data[20:0];
        rcp_pkg::CFG_MAX_BULK:   max_bulk_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic rcp_pkg::result_t mk(logic [1:0] k, logic [7:0] b, logic f,
                                          logic [20:0] idx, logic [29:0] len,
                                          logic [20:0] c, logic [2:0] code);
    rcp_pkg::result_t r;
    r.kind = k; r.out_byte = b; r.first_of_arg = f; r.arg_index = idx[19:0];
    r.arg_length = len; r.arg_count = c; r.error_code = code; r.last_of_run = 1'b0;
    return r;
  endfunction

  // scratch values of combinational decode
  logic        line_end, is_sp;
  logic [16:0] ll_inc;
  logic [35:0] mul;
  logic [16:0] clen;
  logic        nvalid;

  always_comb begin
    logic [7:0] b;
    b = in_byte;
    phase_nxt = phase_r; cr_nxt = cr_r; inv_nxt = inv_r; neg_nxt = neg_r;
    dig_nxt = dig_r; inw_nxt = inw_r; fc_nxt = fc_r; acc_nxt = acc_r;
    exp_nxt = exp_r; cur_nxt = cur_r; rem_nxt = rem_r; trl_nxt = trl_r;
    ll_nxt = ll_r; wl_nxt = wl_r;
    r0 = '0; r1 = '0; nres = 2'd0;
    line_end = 1'b0;
    is_sp = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    ll_inc = 17'd0; mul = 36'd0; clen = 17'd0; nvalid = 1'b0;

    if (in_cmd) begin
      phase_nxt = rcp_pkg::PH_IDLE; cr_nxt = 1'b0; inv_nxt = 1'b0; neg_nxt = 1'b0;
      dig_nxt = 1'b0; inw_nxt = 1'b0; fc_nxt = '0; acc_nxt = '0; exp_nxt = '0;
      cur_nxt = '0; rem_nxt = '0; trl_nxt = '0; ll_nxt = '0; wl_nxt = '0;
    end else begin
      if (phase_r == rcp_pkg::PH_IDLE) begin
        cr_nxt = 1'b0; inv_nxt = 1'b0; fc_nxt = '0; acc_nxt = '0;
        neg_nxt = 1'b0; dig_nxt = 1'b0; ll_nxt = '0;
      end
      unique case (phase_r)
        rcp_pkg::PH_IDLE: begin
          if (b == 8'h2A) begin
            // first byte of count line: set length and first char, enter count phase
            fc_nxt = b; ll_nxt = 17'd1; phase_nxt = rcp_pkg::PH_COUNT;
            if (17'd1 > max_inline_r) begin
              r0 = mk(rcp_pkg::K_ERROR, 8'h2A, 1'b0, '0, '0, '0,
                      rcp_pkg::E_COUNT_LONG);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
            end
          end else begin
            cur_nxt = '0; inw_nxt = 1'b0; wl_nxt = '0; fc_nxt = b;
            phase_nxt = rcp_pkg::PH_INLINE;
            if (b == 8'h0A) begin
              r0 = mk(rcp_pkg::K_DONE, '0, 1'b0, '0, '0, '0, '0);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_IDLE;
            end else begin
              ll_nxt = 17'd1;
              if (17'd1 > max_inline_r) begin
                r0 = mk(rcp_pkg::K_ERROR, b, 1'b0, '0, '0, '0,
                        rcp_pkg::E_INLINE_LONG);
                nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
              end else if (!is_sp) begin
                r0 = mk(rcp_pkg::K_BYTE, b, 1'b1, '0, '0, '0, '0);
                nres = 2'd1; inw_nxt = 1'b1; wl_nxt = 17'd1;
              end
            end
          end
        end
        rcp_pkg::PH_INLINE: begin
          if (b == 8'h0A) begin
            if (inw_r) begin
              r0 = mk(rcp_pkg::K_END, '0, 1'b0, cur_r, {13'd0, wl_r}, '0, '0);
              r1 = mk(rcp_pkg::K_DONE, '0, 1'b0, '0, '0, cur_r + 21'd1, '0);
              nres = 2'd2; cur_nxt = cur_r + 21'd1; inw_nxt = 1'b0;
            end else begin
              r0 = mk(rcp_pkg::K_DONE, '0, 1'b0, '0, '0, cur_r, '0);
              nres = 2'd1;
            end
            phase_nxt = rcp_pkg::PH_IDLE;
          end else begin
            ll_inc = (ll_r == rcp_pkg::LEN_SAT) ? ll_r : ll_r + 17'd1;
            ll_nxt = ll_inc;
            if (ll_inc > max_inline_r) begin
              r0 = mk(rcp_pkg::K_ERROR, fc_r, 1'b0, '0, '0, '0,
                      rcp_pkg::E_INLINE_LONG);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
            end else if (is_sp) begin
              if (inw_r) begin
                r0 = mk(rcp_pkg::K_END, '0, 1'b0, cur_r, {13'd0, wl_r}, '0, '0);
                nres = 2'd1; cur_nxt = cur_r + 21'd1; inw_nxt = 1'b0;
              end
            end else begin
              r0 = mk(rcp_pkg::K_BYTE, b, !inw_r, cur_r, '0, '0, '0);
              nres = 2'd1; inw_nxt = 1'b1;
              if (!inw_r) wl_nxt = 17'd1;
              else if (wl_r != rcp_pkg::LEN_SAT) wl_nxt = wl_r + 17'd1;
            end
          end
        end
        rcp_pkg::PH_COUNT, rcp_pkg::PH_HEADER: begin
          ll_inc = (ll_r == rcp_pkg::LEN_SAT) ? ll_r : ll_r + 17'd1;
          if (cr_r && b == 8'h0A) begin
            line_end = 1'b0;
            cr_nxt = 1'b0;
            line_end = 1'b1;
          end else begin
            if (cr_r) begin inv_nxt = 1'b1; cr_nxt = 1'b0; end
            ll_nxt = ll_inc;
            if (b == 8'h0D) begin
              if (ll_r == 17'd0) fc_nxt = b;
              cr_nxt = 1'b1;
            end else if (ll_r == 17'd0) begin
              fc_nxt = b;
            end else if (ll_r == 17'd1 && (b == 8'h2D || b == 8'h2B)) begin
              neg_nxt = (b == 8'h2D);
            end else if (b >= 8'h30 && b <= 8'h39) begin
              if (!inv_nxt) begin
                mul = {4'd0, acc_r} * 36'd10 + {28'd0, b - 8'h30};
                if (mul > {3'd0, rcp_pkg::NUM_LIMIT}) inv_nxt = 1'b1;
                else acc_nxt = mul[31:0];
              end
              dig_nxt = 1'b1;
            end else begin
              inv_nxt = 1'b1;
            end
          end
          nvalid = !inv_r && dig_r;
          if (phase_r == rcp_pkg::PH_COUNT) begin
            if (line_end) begin
              if (!nvalid || (!neg_r && acc_r > {11'd0, max_args_r})) begin
                r0 = mk(rcp_pkg::K_ERROR, 8'h2A, 1'b0, '0, '0, '0,
                        rcp_pkg::E_BAD_COUNT);
                nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
              end else if (neg_r || acc_r == 32'd0) begin
                r0 = mk(rcp_pkg::K_DONE, '0, 1'b0, '0, '0, '0, '0);
                nres = 2'd1; phase_nxt = rcp_pkg::PH_IDLE;
              end else begin
                exp_nxt = acc_r[20:0]; cur_nxt = '0;
                cr_nxt = 1'b0; inv_nxt = 1'b0; fc_nxt = '0; acc_nxt = '0;
                neg_nxt = 1'b0; dig_nxt = 1'b0; ll_nxt = '0;
                phase_nxt = rcp_pkg::PH_HEADER;
              end
            end else if (ll_nxt > max_inline_r) begin
              r0 = mk(rcp_pkg::K_ERROR, 8'h2A, 1'b0, '0, '0, '0,
                      rcp_pkg::E_COUNT_LONG);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
            end
          end else if (line_end) begin
            clen = ll_r - 17'd1;
            if (clen == 17'd0 || fc_r != 8'h24) begin
              r0 = mk(rcp_pkg::K_ERROR, (clen == 17'd0) ? 8'h00 : fc_r, 1'b0,
                      '0, '0, '0, rcp_pkg::E_EXP_DOLLAR);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
            end else if (!nvalid || (neg_r && acc_r != 32'd0) ||
                         acc_r > {2'd0, max_bulk_r}) begin
              r0 = mk(rcp_pkg::K_ERROR, 8'h24, 1'b0, '0, '0, '0,
                      rcp_pkg::E_BAD_LEN);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_ERROR;
            end else begin
              rem_nxt = acc_r[29:0];
              if (acc_r == 32'd0) begin
                r0 = mk(rcp_pkg::K_END, '0, 1'b0, cur_r, '0, '0, '0);
                nres = 2'd1; cur_nxt = cur_r + 21'd1; trl_nxt = 2'd2;
                phase_nxt = rcp_pkg::PH_TRAILER;
              end else begin
                phase_nxt = rcp_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        rcp_pkg::PH_PAYLOAD: begin
          r0 = mk(rcp_pkg::K_BYTE, b, rem_r == acc_r[29:0], cur_r, '0, '0, '0);
          nres = 2'd1;
          rem_nxt = rem_r - 30'd1;
          if (rem_r == 30'd1) begin
            r1 = mk(rcp_pkg::K_END, '0, 1'b0, cur_r, acc_r[29:0], '0, '0);
            nres = 2'd2; cur_nxt = cur_r + 21'd1; trl_nxt = 2'd2;
            phase_nxt = rcp_pkg::PH_TRAILER;
          end
        end
        rcp_pkg::PH_TRAILER: begin
          if (trl_r != 2'd0) trl_nxt = trl_r - 2'd1;
          if (trl_r <= 2'd1) begin
            if (cur_r >= exp_r) begin
              r0 = mk(rcp_pkg::K_DONE, '0, 1'b0, '0, '0, cur_r, '0);
              nres = 2'd1; phase_nxt = rcp_pkg::PH_IDLE;
            end else begin
              cr_nxt = 1'b0; inv_nxt = 1'b0; fc_nxt = '0; acc_nxt = '0;
              neg_nxt = 1'b0; dig_nxt = 1'b0; ll_nxt = '0;
              phase_nxt = rcp_pkg::PH_HEADER;
            end
          end
        end
        default: ;
      endcase
    end
    if (nres == 2'd1) r0.last_of_run = 1'b1;
    if (nres == 2'd2) r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rcp_pkg::PH_IDLE; cr_r <= 1'b0; inv_r <= 1'b0; neg_r <= 1'b0;
      dig_r <= 1'b0; inw_r <= 1'b0; fc_r <= '0; acc_r <= '0; exp_r <= '0;
      cur_r <= '0; rem_r <= '0; trl_r <= '0; ll_r <= '0; wl_r <= '0;
    end else if (acc_in) begin
      phase_r <= phase_nxt; cr_r <= cr_nxt; inv_r <= inv_nxt; neg_r <= neg_nxt;
      dig_r <= dig_nxt; inw_r <= inw_nxt; fc_r <= fc_nxt; acc_r <= acc_nxt;
      exp_r <= exp_nxt; cur_r <= cur_nxt; rem_r <= rem_nxt; trl_r <= trl_nxt;
      ll_r <= ll_nxt; wl_r <= wl_nxt;
    end
  end

  logic [1:0] n_push;
  assign n_push = acc_in ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo_r[wp_r] <= r0;
    if (n_push == 2'd2) fifo_r[wp_r + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push;
      rp_r  <= rp_r + {1'b0, acc_out};
      cnt_r <= cnt_r + {1'b0, n_push} - {2'd0, acc_out};
    end
  end

  rcp_pkg::result_t head;
  assign head = fifo_r[rp_r];
  assign out_kind         = head.kind;
  assign out_byte         = head.out_byte;
  assign out_first_of_arg = head.first_of_arg;
  assign out_arg_index    = head.arg_index;
  assign out_arg_length   = head.arg_length;
  assign out_arg_count    = head.arg_count;
  assign out_error_code   = head.error_code;
  assign out_last_of_run  = head.last_of_run;

endmodule

/* dv/resp_command_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_command_parser_checker
// Watches the config, request and result channels of the parser. It keeps its
// own copy of the parser state and limits, and works out the results of each
// accepted request. Each accepted result is compared field by field with the
// oldest result still expected.
// ----------------------------------------------------------------------------
module resp_command_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic        out_first_of_arg,
  input  logic [19:0] out_arg_index,
  input  logic [29:0] out_arg_length,
  input  logic [20:0] out_arg_count,
  input  logic [2:0]  out_error_code,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending
);

  logic [16:0] lim_inline;
  logic [20:0] lim_args;
  logic [29:0] lim_bulk;

  logic [3:0]  ph;
  bit          cr_seen, bad_line, neg, got_digit, in_word;
  logic [7:0]  first_ch;
  logic [31:0] acc;
  logic [20:0] want_args, arg_no;
  logic [29:0] pay_left;
  logic [1:0]  trl_left;
  logic [16:0] line_len, word_len;

  rcp_pkg::result_t parsed_q[$];

  function automatic void push_res(logic [1:0] k, logic [7:0] b, bit f, logic [20:0] idx,
                                   logic [29:0] len, logic [20:0] cnt, logic [2:0] code);
    rcp_pkg::result_t r;
    r.kind = k;
    r.out_byte = b;
    r.first_of_arg = f;
    r.arg_index = idx[19:0];
    r.arg_length = len;
    r.arg_count = cnt;
    r.error_code = code;
    r.last_of_run = 1'b0;
    parsed_q.insert(parsed_q.size(), r);
  endfunction

  function automatic void raise_error(logic [7:0] b, logic [2:0] code);
    push_res(rcp_pkg::K_ERROR, b, 0, '0, '0, '0, code);
    ph = rcp_pkg::PH_ERROR;
  endfunction

  function automatic void clear_line();
    cr_seen = 0;
    bad_line = 0;
    first_ch = '0;
    acc = '0;
    neg = 0;
    got_digit = 0;
    line_len = '0;
  endfunction

  function automatic void bump_len();
    if (line_len != rcp_pkg::LEN_SAT) line_len++;
  endfunction

  function automatic void parser_clear();
    ph = rcp_pkg::PH_IDLE;
    clear_line();
    want_args = '0;
    arg_no = '0;
    pay_left = '0;
    trl_left = '0;
    word_len = '0;
    in_word = 0;
  endfunction

  function automatic void take_content(logic [7:0] b);
    longint v;
    if (line_len == 0) begin
      first_ch = b;
    end else if (line_len == 1 && (b == "-" || b == "+")) begin
      neg = (b == "-");
    end else if (b >= "0" && b <= "9") begin
      if (!bad_line) begin
        v = longint'(acc) * 10 + longint'(b - "0");
        if (v > longint'(rcp_pkg::NUM_LIMIT)) bad_line = 1;
        else acc = v[31:0];
      end
      got_digit = 1;
    end else begin
      bad_line = 1;
    end
    bump_len();
  endfunction

  // 1 when the byte completes a CRLF
  function automatic bit take_line_byte(logic [7:0] b);
    if (cr_seen && b == 8'h0A) begin
      cr_seen = 0;
      return 1;
    end
    if (cr_seen) begin
      bad_line = 1;
      cr_seen = 0;
    end
    if (b == 8'h0D) begin
      if (line_len == 0) first_ch = b;
      bump_len();
      cr_seen = 1;
    end else begin
      take_content(b);
    end
    return 0;
  endfunction

  function automatic void inline_step(logic [7:0] b);
    if (b == 8'h0A) begin
      if (in_word) begin
        push_res(rcp_pkg::K_END, '0, 0, arg_no, 30'(word_len), '0, '0);
        arg_no++;
        in_word = 0;
      end
      push_res(rcp_pkg::K_DONE, '0, 0, '0, '0, arg_no, '0);
      ph = rcp_pkg::PH_IDLE;
      return;
    end
    bump_len();
    if (line_len > lim_inline) begin
      raise_error(first_ch, rcp_pkg::E_INLINE_LONG);
    end else if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
      if (in_word) begin
        push_res(rcp_pkg::K_END, '0, 0, arg_no, 30'(word_len), '0, '0);
        arg_no++;
        in_word = 0;
      end
    end else begin
      push_res(rcp_pkg::K_BYTE, b, !in_word, arg_no, '0, '0, '0);
      if (!in_word) begin
        in_word = 1;
        word_len = '0;
      end
      if (word_len != rcp_pkg::LEN_SAT) word_len++;
    end
  endfunction

  function automatic void count_done();
    if (bad_line || !got_digit || (!neg && acc > 32'(lim_args))) begin
      raise_error("*", rcp_pkg::E_BAD_COUNT);
    end else if (neg || acc == 0) begin
      push_res(rcp_pkg::K_DONE, '0, 0, '0, '0, '0, '0);
      ph = rcp_pkg::PH_IDLE;
    end else begin
      want_args = acc[20:0];
      arg_no = '0;
      clear_line();
      ph = rcp_pkg::PH_HEADER;
    end
  endfunction

  function automatic void header_done();
    logic [16:0] clen;
    clen = line_len - 17'd1;
    if (clen == 0 || first_ch != "$") begin
      raise_error(clen == 0 ? 8'h00 : first_ch, rcp_pkg::E_EXP_DOLLAR);
    end else if (bad_line || !got_digit || (neg && acc != 0) || acc > 32'(lim_bulk)) begin
      raise_error("$", rcp_pkg::E_BAD_LEN);
    end else begin
      pay_left = acc[29:0];
      if (pay_left == 0) begin
        push_res(rcp_pkg::K_END, '0, 0, arg_no, '0, '0, '0);
        arg_no++;
        trl_left = 2'd2;
        ph = rcp_pkg::PH_TRAILER;
      end else begin
        ph = rcp_pkg::PH_PAYLOAD;
      end
    end
  endfunction

  function automatic void parse_request(logic c, logic [7:0] b);
    int before_n;
    before_n = parsed_q.size();
    if (c) begin
      parser_clear();
      return;
    end
    case (ph)
      rcp_pkg::PH_IDLE: begin
        clear_line();
        if (b == "*") begin
          ph = rcp_pkg::PH_COUNT;
          void'(take_line_byte(b));
          if (line_len > lim_inline) raise_error("*", rcp_pkg::E_COUNT_LONG);
        end else begin
          ph = rcp_pkg::PH_INLINE;
          arg_no = '0;
          in_word = 0;
          word_len = '0;
          first_ch = b;
          inline_step(b);
        end
      end
      rcp_pkg::PH_INLINE: inline_step(b);
      rcp_pkg::PH_COUNT: begin
        if (take_line_byte(b)) count_done();
        else if (line_len > lim_inline) raise_error("*", rcp_pkg::E_COUNT_LONG);
      end
      rcp_pkg::PH_HEADER: if (take_line_byte(b)) header_done();
      rcp_pkg::PH_PAYLOAD: begin
        push_res(rcp_pkg::K_BYTE, b, pay_left == acc[29:0], arg_no, '0, '0, '0);
        pay_left--;
        if (pay_left == 0) begin
          push_res(rcp_pkg::K_END, '0, 0, arg_no, acc[29:0], '0, '0);
          arg_no++;
          trl_left = 2'd2;
          ph = rcp_pkg::PH_TRAILER;
        end
      end
      rcp_pkg::PH_TRAILER: begin
        if (trl_left > 0) trl_left--;
        if (trl_left == 0) begin
          if (arg_no >= want_args) begin
            push_res(rcp_pkg::K_DONE, '0, 0, '0, '0, arg_no, '0);
            ph = rcp_pkg::PH_IDLE;
          end else begin
            clear_line();
            ph = rcp_pkg::PH_HEADER;
          end
        end
      end
      default: ;
    endcase
    if (parsed_q.size() > before_n) parsed_q[$].last_of_run = 1'b1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    rcp_pkg::result_t w;
    if (parsed_q.size() == 0) begin
      report("unexpected result kind", out_kind, 0);
      return;
    end
    w = parsed_q.pop_front();
    if (out_kind != w.kind)                 report("kind", out_kind, w.kind);
    if (out_byte != w.out_byte)             report("byte", out_byte, w.out_byte);
    if (out_first_of_arg != w.first_of_arg) report("first_of_arg", out_first_of_arg,
                                                   w.first_of_arg);
    if (out_arg_index != w.arg_index)       report("arg_index", out_arg_index, w.arg_index);
    if (out_arg_length != w.arg_length)     report("arg_length", out_arg_length, w.arg_length);
    if (out_arg_count != w.arg_count)       report("arg_count", out_arg_count, w.arg_count);
    if (out_error_code != w.error_code)     report("error_code", out_error_code, w.error_code);
    if (out_last_of_run != w.last_of_run)   report("last_of_run", out_last_of_run,
                                                   w.last_of_run);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_inline = 17'd65536;
      lim_args = 21'd1048576;
      lim_bulk = 30'd536870912;
      parser_clear();
      parsed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcp_pkg::CFG_MAX_INLINE: lim_inline = cfg_data[16:0];
          rcp_pkg::CFG_MAX_ARGS:   lim_args = cfg_data[20:0];
          rcp_pkg::CFG_MAX_BULK:   lim_bulk = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_request(in_cmd, in_byte);
    end
    pending = parsed_q.size();
  end

endmodule

/* dv/resp_command_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_command_parser_tb
// Feeds the parser array and inline commands, broken commands and noise under
// several limit settings, with random stalls on both channels and one long
// result backpressure stretch. The checker predicts and compares.
// ----------------------------------------------------------------------------
module resp_command_parser_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;
  logic        in_valid, in_ready, in_cmd;
  logic [7:0]  in_byte;
  logic        out_valid, out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_first_of_arg;
  logic [19:0] out_arg_index;
  logic [29:0] out_arg_length;
  logic [20:0] out_arg_count;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;
  int          fail_count, pending;

  bit          quiet;
  bit          hold_req;
  int          stall_cnt;
  logic [8:0]  byte_q[$];

  resp_command_parser dut (.*);
  resp_command_parser_checker chk (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void put_str(string s);
    foreach (s[i]) byte_q.insert(byte_q.size(), {1'b0, s[i]});
  endfunction

  function automatic void put_byte(logic [7:0] b);
    byte_q.insert(byte_q.size(), {1'b0, b});
  endfunction

  function automatic void put_restart();
    byte_q.insert(byte_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic void gen_array();
    int n, len, pick;
    string cnt;
    n = $urandom_range(0, 4);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      cnt = "-1";
      n = 0;
    end else if (pick == 1) begin
      cnt = $sformatf("+%0d", n);
    end else begin
      cnt = $sformatf("%0d", n);
    end
    put_str({"*", cnt, "\r\n"});
    for (int a = 0; a < n; a++) begin
      len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) put_str($sformatf("$+%0d\r\n", len));
      else put_str($sformatf("$%0d\r\n", len));
      repeat (len) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_str("\r\n");
      end
    end
  endfunction

  function automatic void gen_inline();
    logic [7:0] c;
    int words;
    logic [7:0] seps[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    words = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) put_byte(seps[$urandom_range(0, 4)]);
    for (int w = 0; w < words; w++) begin
      repeat ($urandom_range(1, 5)) begin
        c = 8'($urandom_range(0, 255));
        if (c == 8'h0A) c = 8'h41;
        if (byte_q.size() == 0 || c == "*") c = (c == "*") ? 8'h7E : c;
        put_byte(c);
      end
      put_byte(seps[$urandom_range(0, 4)]);
    end
    put_byte(8'h0A);
  endfunction

  function automatic void gen_broken();
    case ($urandom_range(0, 7))
      0: repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
      1: put_str("*a1\r\n");
      2: put_str("*99999999999\r\n");
      3: put_str("*2\r\nX3\r\n");
      4: put_str("*1\r\n$-3\r\n");
      5: put_str("*1\r\n\r\n");
      6: put_str("*1\r\n$9999999\r\n");
      default: put_str("*1\r\r\n");
    endcase
    put_restart();
  endfunction

  task automatic send(logic [8:0] item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= item[8];
    in_byte  <= item[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_stream();
    while (byte_q.size() > 0) send(byte_q.pop_front());
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [29:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(int lin, int largs, int lbulk);
    // let the checker see the last request before looking at its queue
    @(posedge clk);
    wait (pending == 0);
    repeat (12) @(posedge clk);
    write_reg(rcp_pkg::CFG_MAX_INLINE, 30'(lin));
    write_reg(rcp_pkg::CFG_MAX_ARGS, 30'(largs));
    write_reg(rcp_pkg::CFG_MAX_BULK, 30'(lbulk));
  endtask

  task automatic run_random(int n_items);
    int pick;
    while (byte_q.size() < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) gen_array();
      else if (pick < 8) gen_inline();
      else gen_broken();
      if ($urandom_range(0, 2) == 0) put_restart();
    end
    put_restart();
    drain_stream();
  endtask

  // result side
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_byte = '0;
    quiet = 0;
    hold_req = 0;
    stall_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and negative counts, inline words, bad count, sign, zero length
    put_str("*0\r\n");
    put_str("*-1\r\n");
    put_str("a b\n");
    put_str("*x\r\n");
    put_restart();
    put_str("*1\r\n$0\r\n\r\n");
    drain_stream();

    set_limits(65536, 1048576, 536870912);
    hold_req = 1;
    run_random(130);
    set_limits(8, 3, 4);
    run_random(120);
    set_limits(1, 0, 0);
    run_random(80);
    set_limits(20, 2, 6);
    run_random(120);
    set_limits(65536, 1048576, 536870912);
    quiet = 1;
    run_random(130);

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
